// ===== rtl/core/fmtcw_pkg.sv =====
// Package for the FM tuner control word serializer.
// Holds word layout constants, register indexes and the divider step function.
// No dependencies.
package fmtcw_pkg;

	// Frame and field sizes.
	localparam int unsigned FRAME_BITS    = 25;
	localparam int unsigned POS_W         = 5;
	localparam int unsigned FREQ_W        = 28;
	localparam int unsigned SUM_W         = 29;
	localparam int unsigned DIVIDER_STEPS = 14;
	localparam int unsigned QUO_IDX_W     = $clog2(DIVIDER_STEPS);
	localparam int unsigned CFG_DATA_W    = 4;
	localparam int unsigned CFG_INDEX_W   = 2;

	// Tuning constants.
	localparam int unsigned TUNER_IF_HZ   = 10700000;
	localparam int unsigned FIRST_DIVISOR = 102400000;

	// Bit positions inside the control word.
	localparam int unsigned WB_SEARCH  = 24;
	localparam int unsigned WB_UP      = 23;
	localparam int unsigned WB_MONO    = 22;
	localparam int unsigned WB_DX      = 19;
	localparam int unsigned WB_SENS_HI = 17;
	localparam int unsigned WB_SENS_LO = 16;

	// Configuration register indexes.
	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_MONO_MODE    = 2'd0,
		REG_DISTANT_MODE = 2'd1,
		REG_SENS_LEVEL   = 2'd2
	} cfg_reg_t;

	// Sensitivity level settings and the codes they map to.
	localparam logic [CFG_DATA_W-1:0] SENS_VERY_LOW = 4'd0;
	localparam logic [CFG_DATA_W-1:0] SENS_LOW      = 4'd1;
	localparam logic [CFG_DATA_W-1:0] SENS_MEDIUM   = 4'd2;
	localparam logic [CFG_DATA_W-1:0] SENS_RESET    = 4'd10;
	localparam logic [1:0] SCODE_VERY_LOW = 2'b11;
	localparam logic [1:0] SCODE_LOW      = 2'b01;
	localparam logic [1:0] SCODE_MEDIUM   = 2'b10;
	localparam logic [1:0] SCODE_HIGH     = 2'b00;

	typedef logic [FRAME_BITS-1:0]    word_t;
	typedef logic [SUM_W-1:0]         rem_t;
	typedef logic [DIVIDER_STEPS-1:0] quo_t;

	// Running state of the successive-subtraction divider.
	typedef struct packed {
		rem_t rem;
		quo_t quo;
	} divacc_t;

	// Runs n subtraction steps, starting at quotient bit hi and going down.
	// The divisor for quotient bit k is FIRST_DIVISOR shifted right by (13 - k).
	function automatic divacc_t div_steps(divacc_t a, int unsigned hi, int unsigned n);
		divacc_t r;
		rem_t d;
		logic [QUO_IDX_W-1:0] idx;
		r = a;
		for (int unsigned j = 0; j < n; j++) begin
			idx = QUO_IDX_W'(hi - j);
			d = rem_t'(FIRST_DIVISOR >> (DIVIDER_STEPS - 1 - idx));
			if (r.rem >= d) begin
				r.rem = r.rem - d;
				r.quo[idx] = 1'b1;
			end
		end
		return r;
	endfunction

endpackage

// ===== rtl/core/fm_tuner_control_word_serializer.sv =====
// FM tuner control word serializer: builds a 25-bit tuner word per item, sends it MSB first.
// The first bit strobes once the item has passed stages s1 to s4, the pending word register and the shift register.
// Throughput: set by the one-bit-per-cycle serial output;
// the next item is taken while a frame is still shifting, so frames follow with no gap.
// Reset clears all control state and loads mono 0, distant 1, sensitivity 10.
// Depends on fmtcw_pkg; the receiver cannot stall the bit stream.
module fm_tuner_control_word_serializer (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic [fmtcw_pkg::FREQ_W-1:0]         tune_freq_hz,
	input  logic                                 do_search,
	input  logic                                 search_upward,
	input  logic                                 cfg_wr_en,
	input  logic [fmtcw_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [fmtcw_pkg::CFG_DATA_W-1:0]     cfg_wdata,
	output logic                                 bit_strobe,
	output logic                                 data_line,
	output logic [fmtcw_pkg::POS_W-1:0]          bit_position,
	output logic                                 last_bit
);
	import fmtcw_pkg::*;

	// Configuration registers.
	logic                  mono_q;
	logic                  distant_q;
	logic [CFG_DATA_W-1:0] sens_q;

	// Divider pipeline.
	logic    v_s1, v_s2, v_s3, v_s4;
	divacc_t acc_s1, acc_s2, acc_s3, acc_s4;
	logic    srch_s1, srch_s2, srch_s3, srch_s4;
	logic    up_s1, up_s2, up_s3, up_s4;
	divacc_t acc_next_s2, acc_next_s3, acc_next_s4, acc_fin;

	// Finished word waiting for the serializer.
	logic  pend_v_q;
	word_t pend_word_q;
	word_t word_next;
	logic [1:0] scode;

	// Serializer.
	logic             act_q;
	word_t            shift_q;
	logic [POS_W-1:0] pos_q;
	logic             accept;
	logic             load;

	assign busy   = v_s1 | v_s2 | v_s3 | v_s4 | pend_v_q;
	assign accept = start & ~busy;
	assign load   = pend_v_q & (~act_q | (pos_q == '0));

	// Configuration writes; unknown indexes are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mono_q    <= 1'b0;
			distant_q <= 1'b1;
			sens_q    <= SENS_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_MONO_MODE:    mono_q    <= cfg_wdata[0];
				REG_DISTANT_MODE: distant_q <= cfg_wdata[0];
				REG_SENS_LEVEL:   sens_q    <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Four subtraction steps per stage, but two in the last stage, which feeds word assembly.
	always_comb begin
		acc_next_s2 = div_steps(acc_s1, 13, 4);
		acc_next_s3 = div_steps(acc_s2, 9, 4);
		acc_next_s4 = div_steps(acc_s3, 5, 4);
		acc_fin     = div_steps(acc_s4, 1, 2);
	end

	// Sensitivity code lookup.
	always_comb begin
		case (sens_q)
			SENS_VERY_LOW: scode = SCODE_VERY_LOW;
			SENS_LOW:      scode = SCODE_LOW;
			SENS_MEDIUM:   scode = SCODE_MEDIUM;
			default:       scode = SCODE_HIGH;
		endcase
	end

	// Control word assembly.
	always_comb begin
		word_next = '0;
		word_next[DIVIDER_STEPS-1:0] = acc_fin.quo;
		word_next[WB_SENS_HI]        = scode[1];
		word_next[WB_SENS_LO]        = scode[0];
		word_next[WB_DX]             = distant_q;
		word_next[WB_MONO]           = mono_q;
		word_next[WB_SEARCH]         = srch_s4;
		word_next[WB_UP]             = srch_s4 & up_s4;
	end

	// Pipeline valid bits and the pending word flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
			v_s3     <= 1'b0;
			v_s4     <= 1'b0;
			pend_v_q <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			if (v_s4) begin
				pend_v_q <= 1'b1;
			end else if (load) begin
				pend_v_q <= 1'b0;
			end
		end
	end

	// Pipeline payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			acc_s1.rem <= rem_t'(tune_freq_hz) + rem_t'(TUNER_IF_HZ);
			acc_s1.quo <= '0;
			srch_s1    <= do_search;
			up_s1      <= search_upward;
		end
		acc_s2  <= acc_next_s2;
		srch_s2 <= srch_s1;
		up_s2   <= up_s1;
		acc_s3  <= acc_next_s3;
		srch_s3 <= srch_s2;
		up_s3   <= up_s2;
		acc_s4  <= acc_next_s4;
		srch_s4 <= srch_s3;
		up_s4   <= up_s3;
		if (v_s4) begin
			pend_word_q <= word_next;
		end
	end

	// Serializer control: loads a waiting word on the last bit or when idle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= 1'b0;
			pos_q <= '0;
		end else if (load) begin
			act_q <= 1'b1;
			pos_q <= POS_W'(FRAME_BITS - 1);
		end else if (act_q) begin
			if (pos_q == '0) begin
				act_q <= 1'b0;
			end else begin
				pos_q <= pos_q - 1'b1;
			end
		end
	end

	// Serializer shift register, MSB first.
	always_ff @(posedge clk) begin
		if (load) begin
			shift_q <= pend_word_q;
		end else if (act_q) begin
			shift_q <= {shift_q[FRAME_BITS-2:0], 1'b0};
		end
	end

	// The data pin is driven inverted.
	assign bit_strobe   = act_q;
	assign data_line    = ~shift_q[FRAME_BITS-1];
	assign bit_position = pos_q;
	assign last_bit     = act_q & (pos_q == '0);

`ifndef NO_ASSERTIONS
	// Only one item travels between the input and the serializer at a time.
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({v_s1, v_s2, v_s3, v_s4, pend_v_q}))
		else $error("more than one item between input and serializer");

	// Within a frame the bit position counts down by one every cycle.
	a_pos_counts_down: assert property (@(posedge clk) disable iff (!arst_n)
		(bit_strobe && bit_position != '0) |=>
		(bit_strobe && bit_position == $past(bit_position) - 1'b1))
		else $error("frame broken or bit position skipped");

	// A waiting word starts a frame at the top bit when the line is idle.
	a_pending_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(pend_v_q && !bit_strobe) |=>
		(bit_strobe && bit_position == POS_W'(FRAME_BITS - 1)))
		else $error("pending word did not start a frame");
`endif

endmodule

// ===== verif/fm_tuner_control_word_serializer_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the FM tuner control word serializer.
// Runs a directed table and then random tune requests, and checks every serial bit.
// Depends on fmtcw_pkg and the fm_tuner_control_word_serializer RTL.
module fm_tuner_control_word_serializer_tb;
	import fmtcw_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int unsigned DRAIN_CYCLES = 40;
	localparam int unsigned RANDOM_PHASES = 4;
	localparam int unsigned PHASE_ITEMS = 25;
	localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;
	localparam logic [FREQ_W-1:0] FREQ_MAX = {FREQ_W{1'b1}};
	localparam logic [FREQ_W-1:0] FREQ_TOP_OF_BAND = 28'd194099999;
	localparam logic [CFG_DATA_W-1:0] SENS_TOP = 4'd15;

	// One serial bit as it should appear on the result ports.
	typedef struct packed {
		logic data;
		logic [POS_W-1:0] pos;
		logic last;
	} serial_bit_t;

	// One row of the directed table. When known is set, word is the expected
	// control word; otherwise the word is predicted.
	typedef struct packed {
		logic cfg_set;
		logic mono;
		logic dx;
		logic [CFG_DATA_W-1:0] sens;
		logic [FREQ_W-1:0] freq;
		logic search;
		logic up;
		logic known;
		word_t word;
	} directed_row_t;

	localparam int unsigned DIRECTED_ROWS = 16;
	localparam int unsigned ROW_IDX_W = $clog2(DIRECTED_ROWS);
	localparam directed_row_t DIRECTED[DIRECTED_ROWS] = '{
		// Settings straight out of reset, with the frequency extremes.
		'{1'b0, 1'b0, 1'b1, SENS_RESET, 28'd0, 1'b0, 1'b0, 1'b1, 25'h0080358},
		'{1'b0, 1'b0, 1'b1, SENS_RESET, FREQ_MAX, 1'b1, 1'b1, 1'b1, 25'h1883FFF},
		// Search upward without search leaves bit 23 clear.
		'{1'b0, 1'b0, 1'b1, SENS_RESET, FREQ_MAX, 1'b0, 1'b1, 1'b1, 25'h0083FFF},
		'{1'b0, 1'b0, 1'b1, SENS_RESET, 28'd87500000, 1'b1, 1'b0, 1'b0, '0},
		'{1'b0, 1'b0, 1'b1, SENS_RESET, 28'd108000000, 1'b1, 1'b1, 1'b0, '0},
		'{1'b0, 1'b0, 1'b1, SENS_RESET, FREQ_TOP_OF_BAND, 1'b0, 1'b0, 1'b0, '0},
		// Just above the band, where the divider saturates.
		'{1'b0, 1'b0, 1'b1, SENS_RESET, 28'd194100000, 1'b0, 1'b1, 1'b0, '0},
		'{1'b0, 1'b0, 1'b1, SENS_RESET, 28'd194087499, 1'b1, 1'b0, 1'b0, '0},
		'{1'b0, 1'b0, 1'b1, SENS_RESET, 28'd12499, 1'b0, 1'b0, 1'b0, '0},
		// The very low, low and medium sensitivity codes, with mono on and distant off.
		'{1'b1, 1'b1, 1'b0, SENS_VERY_LOW, 28'd0, 1'b0, 1'b0, 1'b1, 25'h0430358},
		'{1'b1, 1'b1, 1'b0, SENS_LOW, 28'd0, 1'b0, 1'b0, 1'b1, 25'h0410358},
		'{1'b1, 1'b1, 1'b0, SENS_MEDIUM, 28'd0, 1'b0, 1'b0, 1'b1, 25'h0420358},
		// Unused sensitivity levels fall back to the high code.
		'{1'b1, 1'b0, 1'b1, 4'd3, 28'd100000000, 1'b1, 1'b1, 1'b0, '0},
		'{1'b1, 1'b0, 1'b1, SENS_TOP, 28'd0, 1'b0, 1'b0, 1'b1, 25'h0080358},
		'{1'b0, 1'b0, 1'b1, SENS_TOP, 28'h5555555, 1'b1, 1'b0, 1'b0, '0},
		'{1'b0, 1'b0, 1'b1, SENS_TOP, 28'hAAAAAAA, 1'b0, 1'b1, 1'b0, '0}
	};

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic [FREQ_W-1:0] tune_freq_hz;
	logic do_search;
	logic search_upward;
	logic cfg_wr_en;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;
	logic bit_strobe;
	logic data_line;
	logic [POS_W-1:0] bit_position;
	logic last_bit;

	// Local copy of the register file.
	logic mono_q;
	logic distant_q;
	logic [CFG_DATA_W-1:0] sens_q;

	serial_bit_t pending_bits[$];
	serial_bit_t next_bit;
	int unsigned items_sent;
	int unsigned bits_checked;
	int unsigned settings_used;
	int unsigned mismatches;
	int unsigned cycle_count;

	fm_tuner_control_word_serializer u_top (.*);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Builds the control word for one tune request under the current registers.
	function automatic word_t tuner_word(input logic [FREQ_W-1:0] freq, input logic search,
			input logic up);
		word_t w;
		logic [31:0] remainder;
		logic [31:0] divisor;
		w = '0;
		remainder = 32'(freq) + TUNER_IF_HZ;
		divisor = FIRST_DIVISOR;
		w[WB_MONO] = mono_q;
		w[WB_DX] = distant_q;
		case (sens_q)
			SENS_VERY_LOW: w[WB_SENS_HI:WB_SENS_LO] = SCODE_VERY_LOW;
			SENS_LOW: w[WB_SENS_HI:WB_SENS_LO] = SCODE_LOW;
			SENS_MEDIUM: w[WB_SENS_HI:WB_SENS_LO] = SCODE_MEDIUM;
			default: w[WB_SENS_HI:WB_SENS_LO] = SCODE_HIGH;
		endcase
		if (search) begin
			w[WB_SEARCH] = 1'b1;
			w[WB_UP] = up;
		end
		// Successive subtraction with a halving divisor, top quotient bit first.
		for (int i = DIVIDER_STEPS - 1; i >= 0; i--) begin
			if (remainder >= divisor) begin
				w[POS_W'(i)] = 1'b1;
				remainder = remainder - divisor;
			end
			divisor = divisor >> 1;
		end
		return w;
	endfunction

	// Mostly in-band frequencies, with some above the band and some raw patterns.
	function automatic logic [FREQ_W-1:0] random_freq();
		case ($urandom_range(0, 9))
			7: return FREQ_W'($urandom_range(194100000, 268435455));
			8: return FREQ_W'($urandom);
			9: return FREQ_W'($urandom_range(0, 20000));
			default: return FREQ_W'($urandom_range(0, 194099999));
		endcase
	endfunction

	// Offers one item, waits until it is taken, and queues its 25 serial bits.
	// Start is left high so that a following item can go out back to back.
	task automatic send_item(input logic [FREQ_W-1:0] freq, input logic search,
			input logic up, input word_t word);
		start <= 1'b1;
		tune_freq_hz <= freq;
		do_search <= search;
		search_upward <= up;
		@(posedge clk);
		while (busy !== 1'b0) @(posedge clk);
		for (int k = FRAME_BITS - 1; k >= 0; k--) begin
			pending_bits.push_back('{data: ~word[POS_W'(k)], pos: POS_W'(k),
				last: (k == 0)});
		end
		items_sent++;
	endtask

	// Drives one register write and mirrors it into the local copy.
	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		case (idx)
			REG_MONO_MODE: mono_q = data[0];
			REG_DISTANT_MODE: distant_q = data[0];
			REG_SENS_LEVEL: sens_q = data;
			default: ;
		endcase
	endtask

	// Writes all registers; the one-bit registers get random upper data bits,
	// and a write to the unused index must change nothing.
	task automatic program_regs(input logic mono, input logic dx,
			input logic [CFG_DATA_W-1:0] sens);
		write_reg(REG_MONO_MODE, {3'($urandom), mono});
		write_reg(REG_DISTANT_MODE, {3'($urandom), dx});
		write_reg(REG_SENS_LEVEL, sens);
		write_reg(REG_UNUSED, CFG_DATA_W'($urandom));
		cfg_wr_en <= 1'b0;
		settings_used++;
	endtask

	// Stops offering items and waits until every queued bit has come out.
	task automatic drain();
		start <= 1'b0;
		while (pending_bits.size() != 0 || busy !== 1'b0) @(posedge clk);
	endtask

	// Compares each strobed bit with the oldest queued one.
	always @(posedge clk) begin
		if (arst_n && bit_strobe === 1'b1) begin
			if (pending_bits.size() == 0) begin
				$display("%0t: unexpected bit: data %b pos %0d last %b", $time,
					data_line, bit_position, last_bit);
				mismatches++;
			end else begin
				next_bit = pending_bits.pop_front();
				bits_checked++;
				if (data_line !== next_bit.data) begin
					$display("%0t: data_line expected %b actual %b (pos %0d)", $time,
						next_bit.data, data_line, next_bit.pos);
					mismatches++;
				end
				if (bit_position !== next_bit.pos) begin
					$display("%0t: bit_position expected %0d actual %0d", $time,
						next_bit.pos, bit_position);
					mismatches++;
				end
				if (last_bit !== next_bit.last) begin
					$display("%0t: last_bit expected %b actual %b (pos %0d)", $time,
						next_bit.last, last_bit, next_bit.pos);
					mismatches++;
				end
			end
		end
	end

	// Watchdog on the total run length.
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Timeout after %0d cycles with %0d bits outstanding.", cycle_count,
			pending_bits.size());
		$display("== FAIL ==");
		$finish;
	end

	// Stimulus: reset, directed table, then random phases.
	initial begin
		int unsigned hold_item;
		directed_row_t row;
		word_t word;
		arst_n = 1'b0;
		start = 1'b0;
		tune_freq_hz = '0;
		do_search = 1'b0;
		search_upward = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		mono_q = 1'b0;
		distant_q = 1'b1;
		sens_q = SENS_RESET;
		items_sent = 0;
		bits_checked = 0;
		settings_used = 1;
		mismatches = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table, items back to back within each setting.
		for (int r = 0; r < DIRECTED_ROWS; r++) begin
			row = DIRECTED[ROW_IDX_W'(r)];
			if (row.cfg_set) begin
				drain();
				program_regs(row.mono, row.dx, row.sens);
			end
			word = row.known ? row.word : tuner_word(row.freq, row.search, row.up);
			send_item(row.freq, row.search, row.up, word);
		end

		// Random phases; the last one adds no random idle gaps, only the drain at the hold item.
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			drain();
			case (phase)
				1: program_regs(1'b1, 1'b0, SENS_VERY_LOW);
				2: program_regs(1'b0, 1'b1, SENS_TOP);
				default: program_regs(1'($urandom), 1'($urandom),
					CFG_DATA_W'($urandom_range(0, 15)));
			endcase
			hold_item = $urandom_range(5, 20);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (n == hold_item) begin
					drain();
				end else if (phase < RANDOM_PHASES - 1 && $urandom_range(0, 3) == 0) begin
					start <= 1'b0;
					repeat ($urandom_range(1, 19)) @(posedge clk);
				end
				begin : one_item
					logic [FREQ_W-1:0] freq;
					logic search;
					logic up;
					freq = random_freq();
					search = 1'($urandom);
					up = 1'($urandom);
					send_item(freq, search, up, tuner_word(freq, search, up));
				end
			end
		end

		drain();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Covered %0d tune requests under %0d register settings, %0d bits checked.",
			items_sent, settings_used, bits_checked);
		if (mismatches == 0) begin
			$display("== PASS ==");
		end else begin
			$display("Mismatches: %0d", mismatches);
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
